### sv/qdwd_pkg.sv
// Package for the dual quadrature decoder: operation codes, step codes,
// the control struct for one wheel, and the decode and saturation functions.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package qdwd_pkg;

    // Operation carried in tuser
    typedef enum logic [1:0] {
        OP_PIN_UPDATE = 2'd0,
        OP_CAPTURE    = 2'd1,
        OP_TICK       = 2'd2,
        OP_READ       = 2'd3
    } t_op;

    // Wheel selector values for a read
    localparam logic [1:0] WHEEL_LEFT  = 2'd1;
    localparam logic [1:0] WHEEL_RIGHT = 2'd2;

    localparam int unsigned COUNT_W = 32;
    localparam int unsigned DELTA_W = 16;

    localparam logic signed [DELTA_W-1:0] DELTA_MAX = 16'sh7FFF;
    localparam logic signed [DELTA_W-1:0] DELTA_MIN = 16'sh8000;

    // Counter step for one transition
    typedef enum logic [1:0] {
        STEP_NONE = 2'd0,
        STEP_UP   = 2'd1,
        STEP_DOWN = 2'd2
    } t_step;

    // Per-wheel strobes, valid in the cycle the item is processed
    typedef struct packed {
        logic update;
        logic capture;
        logic tick;
    } t_wheel_ctl;

    // x4 transition table, indexed by {old A, old B, new A, new B}
    function automatic t_step step_lookup(input logic [3:0] idx);
        t_step s;
        case (idx)
            4'd1, 4'd7, 4'd8, 4'd14:  s = STEP_UP;
            4'd2, 4'd4, 4'd11, 4'd13: s = STEP_DOWN;
            default:                  s = STEP_NONE;
        endcase
        return s;
    endfunction

    // Clamp a wrapped 32-bit difference to the signed 16-bit range
    function automatic logic [DELTA_W-1:0] sat_delta(input logic [COUNT_W-1:0] d);
        logic [DELTA_W-1:0] r;
        if (d[COUNT_W-1:DELTA_W-1] == '0 || d[COUNT_W-1:DELTA_W-1] == '1) begin
            r = d[DELTA_W-1:0];
        end else if (d[COUNT_W-1]) begin
            r = DELTA_MIN;
        end else begin
            r = DELTA_MAX;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### sv/qdwd_wheel.sv
// State for one encoder: phase, position counter, tick snapshot and the
// latched saturated window change. Depends on qdwd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module qdwd_wheel
    import qdwd_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_wheel_ctl         i_ctl,
    input  wire logic [1:0]         i_pins,     // {A, B}
    output logic [DELTA_W-1:0]      o_delta
);

    logic [1:0]         r_phase;
    logic [1:0]         n_phase;
    logic [COUNT_W-1:0] r_count;
    logic [COUNT_W-1:0] n_count;
    logic [COUNT_W-1:0] r_last;
    logic [COUNT_W-1:0] n_last;
    logic [DELTA_W-1:0] r_delta;
    logic [DELTA_W-1:0] n_delta;
    t_step              step;

    assign step = step_lookup({r_phase, i_pins});

    // Next state for phase and counter
    always_comb begin
        n_phase = r_phase;
        n_count = r_count;
        if (i_ctl.update) begin
            n_phase = i_pins;
            case (step)
                STEP_UP:   n_count = r_count + COUNT_W'(1);
                STEP_DOWN: n_count = r_count - COUNT_W'(1);
                default:   n_count = r_count;
            endcase
        end else if (i_ctl.capture) begin
            n_phase = i_pins;
        end
    end

    // Window tick: snapshot and saturated change
    always_comb begin
        n_last  = r_last;
        n_delta = r_delta;
        if (i_ctl.tick) begin
            n_last  = r_count;
            n_delta = sat_delta(r_count - r_last);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
            r_count <= '0;
            r_last  <= '0;
            r_delta <= '0;
        end else begin
            r_phase <= n_phase;
            r_count <= n_count;
            r_last  <= n_last;
            r_delta <= n_delta;
        end
    end

    assign o_delta = r_delta;

endmodule

`default_nettype wire

### sv/dual_quadrature_decoder_window_delta.sv
// Top level of the dual quadrature decoder with windowed delta capture.
// Depends on qdwd_pkg and qdwd_wheel.
//
// Usage:
//   Slave channel (i_s_*): one transaction per command. tuser holds the
//   operation (pin update, capture initial state, window tick, read delta),
//   tdata the wheel number and the four encoder pin levels.
//   Master channel (o_m_*): exactly one transaction per command, in order.
//   tdata is the latched signed 16-bit window change for a read of wheel 1
//   (left) or 2 (right), zero for any other wheel number and for all other
//   operations.
//   Pipeline: a command is captured in the input register when accepted,
//   then processed and its result captured in the result register, from
//   which it is offered. Throughput: one command per clock while the receiver
//   takes results; pins may be sampled every cycle without loss.
//   Stall: while the receiver holds tready low the result register keeps its
//   transaction; one more command waits in the input register and the slave
//   tready drops until the result is taken.
//   Reset (synchronous, active low): both phase states, position counters,
//   tick snapshots and latched deltas clear to zero, both channels go empty.
`timescale 1ns / 1ps
`default_nettype none

module dual_quadrature_decoder_window_delta
    import qdwd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // slave channel
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [7:0]  i_s_tdata,   // [1:0] wheel_number, [2] left_a, [3] left_b,
                                          // [4] right_a, [5] right_b, [7:6] zero
    input  wire logic [1:0]  i_s_tuser,   // [1:0] operation
    // master channel
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [15:0]      o_m_tdata    // [15:0] delta_value (signed)
);

    // Input register
    logic         r_in_valid;
    t_op          r_op;
    logic [1:0]   r_wheel;
    logic [1:0]   r_left_pins;
    logic [1:0]   r_right_pins;

    // Result register
    logic               r_out_valid;
    logic [DELTA_W-1:0] r_out_data;
    logic [DELTA_W-1:0] n_out_data;

    logic               advance;
    logic               in_accept;
    t_wheel_ctl         wheel_ctl;
    logic [DELTA_W-1:0] left_delta;
    logic [DELTA_W-1:0] right_delta;

    // The input stage moves on whenever the result register is free or drained
    assign advance    = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || advance;
    assign in_accept  = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_op         <= t_op'(i_s_tuser);
            r_wheel      <= i_s_tdata[1:0];
            r_left_pins  <= i_s_tdata[3:2] == 2'b00 ? 2'b00 : {i_s_tdata[2], i_s_tdata[3]};
            r_right_pins <= {i_s_tdata[4], i_s_tdata[5]};
        end
    end

    // Strobes for the wheel state, only when the item is processed
    always_comb begin
        wheel_ctl.update  = advance && (r_op == OP_PIN_UPDATE);
        wheel_ctl.capture = advance && (r_op == OP_CAPTURE);
        wheel_ctl.tick    = advance && (r_op == OP_TICK);
    end

    qdwd_wheel u_left (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (wheel_ctl),
        .i_pins  (r_left_pins),
        .o_delta (left_delta)
    );

    qdwd_wheel u_right (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (wheel_ctl),
        .i_pins  (r_right_pins),
        .o_delta (right_delta)
    );

    // Result select
    always_comb begin
        n_out_data = '0;
        if (r_op == OP_READ) begin
            if (r_wheel == WHEEL_LEFT) begin
                n_out_data = left_delta;
            end else if (r_wheel == WHEEL_RIGHT) begin
                n_out_data = right_delta;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

`ifndef SYNTHESIS
    // Input side only stalls while a command waits in the input register
    a_ready_only_when_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> r_in_valid)
        else $error("slave tready low with empty input register");

    // A processed command always lands in the result register
    a_advance_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_valid)
        else $error("processed command lost");

    // Non-read commands and reads of unknown wheels return zero
    a_zero_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && (r_op != OP_READ || (r_wheel != WHEEL_LEFT && r_wheel != WHEEL_RIGHT))
        |=> o_m_tdata == '0)
        else $error("nonzero result for a command that returns zero");
`endif

endmodule

`default_nettype wire

### tb/sv/qdwd_delta_checker.sv
`timescale 1ns / 1ps
// Checker for the dual quadrature decoder: keeps its own copy of the wheel state,
// predicts one delta per accepted command and compares it with the result stream.
// Depends on qdwd_pkg.

module qdwd_delta_checker
    import qdwd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [7:0]  i_s_tdata,      // [1:0] wheel_number, [2] left_a, [3] left_b,
                                        // [4] right_a, [5] right_b, [7:6] zero
    input  logic [1:0]  i_s_tuser,      // [1:0] operation
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [15:0] i_m_tdata,      // [15:0] delta_value (signed)
    output int          o_fail_count,
    output int          o_outstanding
);

    // Step of the position within one quadrature cycle
    localparam logic [1:0] QUAD_FWD  = 2'd1;
    localparam logic [1:0] QUAD_BACK = 2'd3;

    typedef struct {
        t_op        op;
        logic [1:0] wheel;
        logic [15:0] delta;
    } t_delta_exp;

    logic [1:0]  phase_ab      [2];
    logic [31:0] position      [2];
    logic [31:0] tick_snapshot [2];
    logic [15:0] window_change [2];
    t_delta_exp  expected_deltas [$];
    int          mismatches = 0;

    // A/B levels to position in the cycle 00 -> 01 -> 11 -> 10
    function automatic logic [1:0] quad_index(input logic [1:0] ab);
        return {ab[1], ab[1] ^ ab[0]};
    endfunction

    // Wrapped 32-bit difference clamped to signed 16 bits
    function automatic logic [15:0] clamp_delta(input logic [31:0] diff);
        if ($signed(diff) > 32'sd32767) begin
            return DELTA_MAX;
        end else if ($signed(diff) < -32'sd32768) begin
            return DELTA_MIN;
        end
        return diff[15:0];
    endfunction

    // Advance the wheel state by one command and return its delta
    task automatic predict_delta(input t_op op, input logic [1:0] wheel,
                                 input logic [1:0] left_ab, input logic [1:0] right_ab,
                                 output logic [15:0] delta);
        logic [1:0]  pins [2];
        logic [1:0]  move;
        logic [31:0] diff;
        pins[0] = left_ab;
        pins[1] = right_ab;
        delta   = '0;
        case (op)
            OP_PIN_UPDATE: begin
                for (int w = 0; w < 2; w++) begin
                    move = quad_index(pins[w]) - quad_index(phase_ab[w]);
                    if (move == QUAD_FWD) begin
                        position[w] = position[w] + 32'd1;
                    end else if (move == QUAD_BACK) begin
                        position[w] = position[w] - 32'd1;
                    end
                    phase_ab[w] = pins[w];
                end
            end
            OP_CAPTURE: begin
                for (int w = 0; w < 2; w++) phase_ab[w] = pins[w];
            end
            OP_TICK: begin
                for (int w = 0; w < 2; w++) begin
                    diff             = position[w] - tick_snapshot[w];
                    tick_snapshot[w] = position[w];
                    window_change[w] = clamp_delta(diff);
                end
            end
            default: begin
                if (wheel == WHEEL_LEFT) begin
                    delta = window_change[0];
                end else if (wheel == WHEEL_RIGHT) begin
                    delta = window_change[1];
                end
            end
        endcase
    endtask

    // Results are checked before the command of the same edge is queued
    always @(posedge i_clk) begin : compare_proc
        t_delta_exp got_exp;
        t_delta_exp new_exp;
        if (!i_rst_n) begin
            for (int w = 0; w < 2; w++) begin
                phase_ab[w]      = '0;
                position[w]      = '0;
                tick_snapshot[w] = '0;
                window_change[w] = '0;
            end
            expected_deltas.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                if (expected_deltas.size() == 0) begin
                    if (mismatches < 10) begin
                        $display("%0t: result %h arrived with no command pending",
                                 $time, i_m_tdata);
                    end
                    mismatches++;
                end else begin
                    got_exp = expected_deltas.pop_front();
                    if (i_m_tdata !== got_exp.delta) begin
                        if (mismatches < 10) begin
                            $display("%0t: %s wheel %0d delta expected %h got %h",
                                     $time, got_exp.op.name(), got_exp.wheel,
                                     got_exp.delta, i_m_tdata);
                        end
                        mismatches++;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                new_exp.op    = t_op'(i_s_tuser);
                new_exp.wheel = i_s_tdata[1:0];
                predict_delta(new_exp.op, new_exp.wheel, {i_s_tdata[2], i_s_tdata[3]},
                              {i_s_tdata[4], i_s_tdata[5]}, new_exp.delta);
                expected_deltas.push_back(new_exp);
            end
        end
        o_fail_count  <= mismatches;
        o_outstanding <= expected_deltas.size();
    end

endmodule

### tb/sv/tb_dual_quadrature_decoder_window_delta.sv
`timescale 1ns / 1ps
// Top of the dual quadrature decoder testbench: clock, reset, command stimulus,
// result-side backpressure and the verdict. Depends on qdwd_pkg, the decoder
// and qdwd_delta_checker.

module tb_dual_quadrature_decoder_window_delta;
    import qdwd_pkg::*;

    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int RAND_ITEMS  = 1450;

    // Moves within one quadrature cycle
    localparam logic [1:0] QUAD_HOLD = 2'd0;
    localparam logic [1:0] QUAD_FWD  = 2'd1;
    localparam logic [1:0] QUAD_SKIP = 2'd2;
    localparam logic [1:0] QUAD_BACK = 2'd3;

    // Wheel numbers that select nothing
    localparam logic [1:0] WHEEL_NONE_LO = 2'd0;
    localparam logic [1:0] WHEEL_NONE_HI = 2'd3;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        s_tvalid   = 1'b0;
    logic [7:0]  s_tdata    = '0;   // [1:0] wheel_number, [2] left_a, [3] left_b,
                                    // [4] right_a, [5] right_b, [7:6] zero
    logic [1:0]  s_tuser    = '0;   // [1:0] operation
    logic        m_tready   = 1'b0;
    logic        s_tready;
    logic        m_tvalid;
    logic [15:0] m_tdata;           // [15:0] delta_value (signed)

    int          fail_count;
    int          outstanding;
    int          cycle_count = 0;
    bit          bursts_on   = 1'b1;
    bit          hold_req    = 1'b0;
    logic [1:0]  cur_left    = '0;
    logic [1:0]  cur_right   = '0;
    logic [1:0]  drift [2]   = '{QUAD_FWD, QUAD_BACK};

    dual_quadrature_decoder_window_delta DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)
    );

    qdwd_delta_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_s_tvalid    (s_tvalid),
        .i_s_tready    (s_tready),
        .i_s_tdata     (s_tdata),
        .i_s_tuser     (s_tuser),
        .i_m_tvalid    (m_tvalid),
        .i_m_tready    (m_tready),
        .i_m_tdata     (m_tdata),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    always #10 i_clk = ~i_clk;

    // Run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Next A/B levels after a move along the quadrature cycle
    function automatic logic [1:0] step_ab(input logic [1:0] ab, input logic [1:0] move);
        logic [1:0] p;
        p = {ab[1], ab[1] ^ ab[0]} + move;
        return {p[1], p[1] ^ p[0]};
    endfunction

    // Mostly the window's drift, sometimes back, a hold or a double step
    function automatic logic [1:0] pick_move(input logic [1:0] bias);
        int r;
        r = $urandom_range(0, 9);
        if (r < 6) return bias;
        if (r < 8) return bias ^ 2'b10;
        if (r < 9) return QUAD_HOLD;
        return QUAD_SKIP;
    endfunction

    // One command transaction; starts and returns at a falling edge
    task automatic send_cmd(input t_op op, input logic [1:0] wheel,
                            input logic [1:0] left_ab, input logic [1:0] right_ab);
        if (bursts_on && $urandom_range(0, 5) == 0) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge i_clk);
        end
        s_tuser  = op;
        s_tdata  = {2'b00, right_ab[0], right_ab[1], left_ab[0], left_ab[1], wheel};
        s_tvalid = 1'b1;
        do @(posedge i_clk); while (!s_tready);
        @(negedge i_clk);
        if (op == OP_PIN_UPDATE || op == OP_CAPTURE) begin
            cur_left  = left_ab;
            cur_right = right_ab;
        end
    endtask

    // Result-side backpressure: random bursts and one long hold-off
    initial begin
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                m_tready = 1'b0;
                repeat (300) @(negedge i_clk);
                hold_req = 1'b0;
            end else if (bursts_on && $urandom_range(0, 7) == 0) begin
                m_tready = 1'b0;
                repeat ($urandom_range(1, 7) - 1) @(negedge i_clk);
            end else begin
                m_tready = 1'b1;
            end
        end
    end

    // Command stimulus and verdict
    initial begin
        int         kind;
        logic [1:0] wheel;
        logic [1:0] l_ab;
        logic [1:0] r_ab;

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reads straight after reset, every wheel number
        send_cmd(OP_READ, WHEEL_NONE_LO, 2'b00, 2'b00);
        send_cmd(OP_READ, WHEEL_LEFT, 2'b11, 2'b11);
        send_cmd(OP_READ, WHEEL_RIGHT, 2'b01, 2'b10);
        send_cmd(OP_READ, WHEEL_NONE_HI, 2'b10, 2'b01);

        // Capture, then a full cycle forward on the left and backward on the right
        send_cmd(OP_CAPTURE, WHEEL_NONE_HI, 2'b10, 2'b01);
        repeat (4) begin
            send_cmd(OP_PIN_UPDATE, WHEEL_LEFT, step_ab(cur_left, QUAD_FWD),
                     step_ab(cur_right, QUAD_BACK));
        end
        // Pins unchanged, then both phases flipping at once
        send_cmd(OP_PIN_UPDATE, WHEEL_RIGHT, cur_left, cur_right);
        send_cmd(OP_PIN_UPDATE, WHEEL_NONE_LO, step_ab(cur_left, QUAD_SKIP),
                 step_ab(cur_right, QUAD_SKIP));
        send_cmd(OP_TICK, WHEEL_LEFT, 2'b11, 2'b11);
        send_cmd(OP_READ, WHEEL_NONE_LO, 2'b00, 2'b00);
        send_cmd(OP_READ, WHEEL_LEFT, 2'b00, 2'b00);
        send_cmd(OP_READ, WHEEL_RIGHT, 2'b00, 2'b00);
        send_cmd(OP_READ, WHEEL_NONE_HI, 2'b00, 2'b00);

        // Recapture mid-cycle, one step each way, short window
        send_cmd(OP_CAPTURE, WHEEL_LEFT, 2'b11, 2'b11);
        send_cmd(OP_PIN_UPDATE, WHEEL_NONE_HI, step_ab(cur_left, QUAD_BACK),
                 step_ab(cur_right, QUAD_FWD));
        send_cmd(OP_TICK, WHEEL_RIGHT, 2'b00, 2'b11);
        send_cmd(OP_READ, WHEEL_LEFT, 2'b01, 2'b10);
        send_cmd(OP_READ, WHEEL_RIGHT, 2'b10, 2'b01);

        // Random commands, biased toward legal pin sequences
        for (int n = 0; n < RAND_ITEMS; n++) begin
            if (n == RAND_ITEMS - 150) bursts_on = 1'b0;
            if (n == 400) hold_req = 1'b1;
            if (n == 800) begin
                s_tvalid = 1'b0;
                wait (outstanding == 0);
                @(negedge i_clk);
            end
            kind  = $urandom_range(0, 99);
            wheel = 2'($urandom_range(0, 3));
            l_ab  = 2'($urandom);
            r_ab  = 2'($urandom);
            if (kind < 65) begin
                send_cmd(OP_PIN_UPDATE, wheel, step_ab(cur_left, pick_move(drift[0])),
                         step_ab(cur_right, pick_move(drift[1])));
            end else if (kind < 72) begin
                send_cmd(OP_CAPTURE, wheel, l_ab, r_ab);
            end else if (kind < 82) begin
                send_cmd(OP_TICK, wheel, l_ab, r_ab);
                drift[0] = $urandom_range(0, 1) ? QUAD_FWD : QUAD_BACK;
                drift[1] = $urandom_range(0, 1) ? QUAD_FWD : QUAD_BACK;
            end else begin
                send_cmd(OP_READ, wheel, l_ab, r_ab);
            end
        end

        // Drain and decide
        s_tvalid = 1'b0;
        wait (outstanding == 0);
        repeat (10) @(posedge i_clk);
        if (fail_count == 0 && outstanding == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
